@@ rtl/core/bpl_pkg.sv @@
// Package for the bounded positional list: payload words, command and status codes,
// controller states and the control/status structs between controller and datapath.
// No dependencies.
package bpl_pkg;

   localparam logic [6:0] LIMIT_RESET = 7'd64;

   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_READ  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_code_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2,
      ST_EMPTY = 2'd3
   } status_code_type;

   typedef struct packed {
      logic [1:0]        cmd;
      logic signed [7:0] position;
      logic [31:0]       data_value;
   } req_word_type;

   typedef struct packed {
      logic [31:0] value;
      logic [1:0]  status;
      logic [6:0]  entry_count;
   } rsp_word_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_FETCH_RD,
      S_FETCH,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_INSERT,
      S_POP_END,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic decode;
      logic fetch_rd;
      logic fetch_take;
      logic cur_load;
      logic shift_rd;
      logic shift_wr;
      logic insert;
      logic pop_end;
      logic load_rsp;
   } ctl_type;

   typedef struct packed {
      logic dec_finish;
      logic is_push;
      logic is_read;
      logic push_shift;
      logic pop_shift;
      logic shift_last;
   } sts_type;

endpackage

@@ rtl/core/bpl_datapath.sv @@
// Datapath of the bounded positional list: entry memory, count, limit register,
// request decode, shift cursor and result word register.
// Depends on bpl_pkg.
module bpl_datapath #(
   parameter int MAX_ENTRIES = 64,
   parameter int DATA_WIDTH  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [6:0]            csr_write_data,
   input  bpl_pkg::req_word_type req_word,
   input  bpl_pkg::ctl_type      ctl,
   output bpl_pkg::sts_type      sts,
   output bpl_pkg::rsp_word_type rsp_word
);

   localparam int AW   = $clog2(MAX_ENTRIES);
   localparam int CW   = $clog2(MAX_ENTRIES + 1);
   localparam int CMPW = (CW > 7) ? CW : 7;

   logic [DATA_WIDTH-1:0] entry_mem [MAX_ENTRIES];

   logic [1:0]                cmd_ff;
   logic [7:0]                pos_ff;
   logic [DATA_WIDTH-1:0]     data_ff;
   logic [6:0]                limit_ff;
   logic [CW-1:0]             count_ff;
   logic [AW-1:0]             p_ff;
   logic [AW-1:0]             cur_ff;
   bpl_pkg::status_code_type  st_ff;
   logic [DATA_WIDTH-1:0]     value_ff;
   logic [DATA_WIDTH-1:0]     rd_data_ff;
   bpl_pkg::rsp_word_type     rsp_ff;

   logic [CMPW-1:0]           count_x;
   logic [CMPW-1:0]           pos_x;
   logic [CMPW-1:0]           lim_x;
   logic [CMPW-1:0]           max_x;
   logic [CMPW-1:0]           cap_x;
   logic [CMPW-1:0]           dec_p_x;
   logic [CMPW-1:0]           p_next_x;
   logic [CW-1:0]             count_m1_w;
   logic [AW-1:0]             count_m1;
   logic [AW-1:0]             wr_addr;
   logic                      pos_neg;
   logic                      list_empty;
   logic                      is_push;
   bpl_pkg::status_code_type  dec_st;
   logic [DATA_WIDTH+31:0]    data_ext;
   logic [DATA_WIDTH+31:0]    value_ext;
   logic [CW+6:0]             count_ext;

   assign count_x    = CMPW'(count_ff);
   assign pos_x      = CMPW'(pos_ff[6:0]);
   assign cap_x      = CMPW'(limit_ff);
   assign max_x      = CMPW'(MAX_ENTRIES);
   assign lim_x      = (cap_x < max_x) ? cap_x : max_x;
   assign pos_neg    = pos_ff[7];
   assign list_empty = (count_ff == '0);
   assign is_push    = (cmd_ff == bpl_pkg::CMD_PUSH);
   assign count_m1_w = count_ff - CW'(1);
   assign count_m1   = count_m1_w[AW-1:0];
   assign p_next_x   = CMPW'(p_ff) + CMPW'(1);
   assign wr_addr    = is_push ? (cur_ff + AW'(1)) : (cur_ff - AW'(1));
   assign data_ext   = {{DATA_WIDTH{1'b0}}, req_word.data_value};
   assign value_ext  = {32'd0, value_ff};
   assign count_ext  = {7'd0, count_ff};

   always_comb begin
      dec_st  = bpl_pkg::ST_OK;
      dec_p_x = pos_x;
      case (cmd_ff)
         bpl_pkg::CMD_PUSH: begin
            if (count_x >= lim_x) begin
               dec_st = bpl_pkg::ST_FULL;
            end else if (list_empty) begin
               dec_p_x = '0;
            end else if (pos_neg || (pos_x > count_x)) begin
               dec_st = bpl_pkg::ST_RANGE;
            end
         end
         bpl_pkg::CMD_POP: begin
            if (list_empty) begin
               dec_st = bpl_pkg::ST_EMPTY;
            end else if (pos_neg) begin
               dec_p_x = count_x - CMPW'(1);
            end else if (pos_x >= count_x) begin
               dec_st = bpl_pkg::ST_RANGE;
            end
         end
         bpl_pkg::CMD_READ: begin
            if (list_empty) begin
               dec_st = bpl_pkg::ST_EMPTY;
            end else if (pos_neg || (pos_x >= count_x)) begin
               dec_st = bpl_pkg::ST_RANGE;
            end
         end
         default: begin
         end
      endcase
   end

   assign sts.dec_finish = (dec_st != bpl_pkg::ST_OK) || (cmd_ff == bpl_pkg::CMD_CLEAR);
   assign sts.is_push    = is_push;
   assign sts.is_read    = (cmd_ff == bpl_pkg::CMD_READ);
   assign sts.push_shift = (dec_p_x < count_x);
   assign sts.pop_shift  = (p_next_x < count_x);
   assign sts.shift_last = is_push ? (cur_ff == p_ff) : (cur_ff == count_m1);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         limit_ff <= bpl_pkg::LIMIT_RESET;
      end else begin
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
         if (ctl.decode && (cmd_ff == bpl_pkg::CMD_CLEAR)) begin
            count_ff <= '0;
         end else if (ctl.insert) begin
            count_ff <= count_ff + CW'(1);
         end else if (ctl.pop_end) begin
            count_ff <= count_m1_w;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff  <= req_word.cmd;
         pos_ff  <= req_word.position;
         data_ff <= data_ext[DATA_WIDTH-1:0];
      end
      if (ctl.decode) begin
         st_ff    <= dec_st;
         value_ff <= '0;
         p_ff     <= dec_p_x[AW-1:0];
      end else if (ctl.fetch_take) begin
         value_ff <= rd_data_ff;
      end
      if (ctl.cur_load) begin
         cur_ff <= is_push ? count_m1 : p_next_x[AW-1:0];
      end else if (ctl.shift_wr) begin
         cur_ff <= is_push ? (cur_ff - AW'(1)) : (cur_ff + AW'(1));
      end
      if (ctl.load_rsp) begin
         rsp_ff.value       <= value_ext[31:0];
         rsp_ff.status      <= st_ff;
         rsp_ff.entry_count <= count_ext[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.fetch_rd) begin
         rd_data_ff <= entry_mem[p_ff];
      end else if (ctl.shift_rd) begin
         rd_data_ff <= entry_mem[cur_ff];
      end
      if (ctl.insert) begin
         entry_mem[p_ff] <= data_ff;
      end else if (ctl.shift_wr) begin
         entry_mem[wr_addr] <= rd_data_ff;
      end
   end

   assign rsp_word = rsp_ff;

endmodule

@@ rtl/core/bpl_controller.sv @@
// Controller of the bounded positional list: sequences decode, fetch, shift and
// commit steps, and owns the request and response handshakes.
// Depends on bpl_pkg.
module bpl_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  bpl_pkg::sts_type sts,
   output bpl_pkg::ctl_type ctl
);

   bpl_pkg::state_type state_ff;
   bpl_pkg::state_type state_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpl_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ctl          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (state_ff)
         bpl_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in    = bpl_pkg::S_DECODE;
            end
         end
         bpl_pkg::S_DECODE: begin
            ctl.decode = 1'b1;
            if (sts.dec_finish) begin
               state_in = bpl_pkg::S_FINISH;
            end else if (sts.is_push) begin
               if (sts.push_shift) begin
                  ctl.cur_load = 1'b1;
                  state_in     = bpl_pkg::S_SHIFT_RD;
               end else begin
                  state_in = bpl_pkg::S_INSERT;
               end
            end else begin
               state_in = bpl_pkg::S_FETCH_RD;
            end
         end
         bpl_pkg::S_FETCH_RD: begin
            ctl.fetch_rd = 1'b1;
            state_in     = bpl_pkg::S_FETCH;
         end
         bpl_pkg::S_FETCH: begin
            ctl.fetch_take = 1'b1;
            if (sts.is_read) begin
               state_in = bpl_pkg::S_FINISH;
            end else if (sts.pop_shift) begin
               ctl.cur_load = 1'b1;
               state_in     = bpl_pkg::S_SHIFT_RD;
            end else begin
               state_in = bpl_pkg::S_POP_END;
            end
         end
         bpl_pkg::S_SHIFT_RD: begin
            ctl.shift_rd = 1'b1;
            state_in     = bpl_pkg::S_SHIFT_WR;
         end
         bpl_pkg::S_SHIFT_WR: begin
            ctl.shift_wr = 1'b1;
            if (sts.shift_last) begin
               state_in = sts.is_push ? bpl_pkg::S_INSERT : bpl_pkg::S_POP_END;
            end else begin
               state_in = bpl_pkg::S_SHIFT_RD;
            end
         end
         bpl_pkg::S_INSERT: begin
            ctl.insert = 1'b1;
            state_in   = bpl_pkg::S_FINISH;
         end
         bpl_pkg::S_POP_END: begin
            ctl.pop_end = 1'b1;
            state_in    = bpl_pkg::S_FINISH;
         end
         bpl_pkg::S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = bpl_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bpl_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/core/bounded_positional_list_unit.sv @@
// Bounded positional list: an ordered list of up to MAX_ENTRIES words with push at
// index, pop at index, read at index and clear. One request word is taken at a time.
// A clear or any error goes from decode to the response register; a read adds a
// fetch; a push moves every entry at or behind the position, then inserts; a pop
// fetches, moves every entry behind the position, then ends. The block takes the next
// request in the cycle after the response register is loaded. A finished word waits
// in the last step while the previous response is still held and not taken.
// The steps are set by the entry memory: it has one read and one write port with a
// registered read, and every entry behind the target index moves by one read and one
// write. The response register holds a finished word while the next request is decoded.
// csr_write_data sets the capacity limit (reset 64); write it only while the block idles.
// Depends on bpl_pkg, bpl_controller and bpl_datapath.
module bounded_positional_list_unit #(
   parameter int MAX_ENTRIES = 64,
   parameter int DATA_WIDTH  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [6:0]            csr_write_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bpl_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bpl_pkg::rsp_word_type rsp_word
);

   bpl_pkg::ctl_type ctl;
   bpl_pkg::sts_type sts;

   bpl_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   bpl_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .DATA_WIDTH  (DATA_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_word         (req_word),
      .ctl              (ctl),
      .sts              (sts),
      .rsp_word         (rsp_word)
   );

endmodule

@@ tb/sv/bounded_positional_list_unit_tb.sv @@
// Self-checking testbench for bounded_positional_list_unit: a scoreboard class predicts
// every response word from the accepted request words and the capacity limit in force.
// Depends on bpl_pkg and the bounded_positional_list_unit RTL.
`timescale 1ns / 100ps

module bounded_positional_list_unit_tb;

   localparam int LIST_DEPTH     = 64;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 150;

   class list_scoreboard;
      logic [31:0]           entries [LIST_DEPTH];
      int                    count;
      int                    limit;
      bpl_pkg::rsp_word_type expected_rsp_q [$];
      int                    errors;
      int                    n_push, n_pop, n_read, n_clear;
      int                    n_full, n_range, n_empty, peak_count;

      function void reset_state();
         count = 0;
         limit = bpl_pkg::LIMIT_RESET;
         expected_rsp_q.delete();
      endfunction

      function void set_limit(logic [6:0] v);
         limit = v;
      endfunction

      function int pending();
         return expected_rsp_q.size();
      endfunction

      function void note_request(bpl_pkg::req_word_type w);
         bpl_pkg::rsp_word_type r;
         int                    p;
         int                    eff;
         r = '0;
         p = $signed(w.position);
         eff = (limit < LIST_DEPTH) ? limit : LIST_DEPTH;
         case (w.cmd)
            bpl_pkg::CMD_PUSH: begin
               n_push++;
               if (count >= eff) begin
                  r.status = bpl_pkg::ST_FULL;
               end else if (count == 0) begin
                  entries[0] = w.data_value;
                  count = 1;
               end else if (p < 0 || p > count) begin
                  r.status = bpl_pkg::ST_RANGE;
               end else begin
                  for (int i = count; i > p; i--) entries[i] = entries[i-1];
                  entries[p] = w.data_value;
                  count++;
               end
            end
            bpl_pkg::CMD_CLEAR: begin
               n_clear++;
               count = 0;
            end
            bpl_pkg::CMD_POP: begin
               n_pop++;
               if (count == 0) begin
                  r.status = bpl_pkg::ST_EMPTY;
               end else begin
                  if (p < 0) p = count - 1;
                  if (p >= count) begin
                     r.status = bpl_pkg::ST_RANGE;
                  end else begin
                     r.value = entries[p];
                     for (int i = p; i < count - 1; i++) entries[i] = entries[i+1];
                     count--;
                  end
               end
            end
            default: begin
               n_read++;
               if (count == 0) r.status = bpl_pkg::ST_EMPTY;
               else if (p < 0 || p >= count) r.status = bpl_pkg::ST_RANGE;
               else r.value = entries[p];
            end
         endcase
         if (r.status == bpl_pkg::ST_FULL) n_full++;
         if (r.status == bpl_pkg::ST_RANGE) n_range++;
         if (r.status == bpl_pkg::ST_EMPTY) n_empty++;
         if (count > peak_count) peak_count = count;
         r.entry_count = count[6:0];
         expected_rsp_q.push_back(r);
      endfunction

      function void check_response(bpl_pkg::rsp_word_type got);
         bpl_pkg::rsp_word_type exp_w;
         if (expected_rsp_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: unexpected response value=%h status=%0d count=%0d",
                        $realtime, got.value, got.status, got.entry_count);
            return;
         end
         exp_w = expected_rsp_q.pop_front();
         if (got.value !== exp_w.value || got.status !== exp_w.status ||
             got.entry_count !== exp_w.entry_count) begin
            errors++;
            if (errors <= 10)
               $display("%0t: expected %h st %0d cnt %0d, got %h st %0d cnt %0d",
                        $realtime, exp_w.value, exp_w.status, exp_w.entry_count,
                        got.value, got.status, got.entry_count);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset            = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic [6:0]            csr_write_data   = '0;
   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   bpl_pkg::req_word_type req_word         = '0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   bpl_pkg::rsp_word_type rsp_word;

   list_scoreboard sb;
   int burst_left;
   int stall_left;
   int cycle_count;
   int idle_cycles;
   int n_settings;

   bounded_positional_list_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_word         (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver: stall pattern moves through three modes (no stalls, short stalls, long stalls)
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_word);
      cycle_count++;
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         case ((cycle_count / 300) % 3)
            0: stall_left = 0;
            1: stall_left = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
            default: stall_left = ($urandom_range(2) == 0) ? $urandom_range(1, 12) : 0;
         endcase
         rsp_ready <= (stall_left == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   function automatic bpl_pkg::req_word_type make_word(bpl_pkg::cmd_code_type c, int pos,
                                                       logic [31:0] d);
      bpl_pkg::req_word_type w;
      w.cmd        = c;
      w.position   = pos[7:0];
      w.data_value = d;
      return w;
   endfunction

   task automatic send_word(bpl_pkg::req_word_type w);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_word  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_request(w);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic change_limit(logic [6:0] v);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      sb.set_limit(v);
      n_settings++;
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(int items, int push_pct, int pop_pct);
      bpl_pkg::req_word_type w;
      int                    roll;
      int                    sel;
      int                    cnt;
      for (int k = 0; k < items; k++) begin
         cnt  = sb.count;
         roll = $urandom_range(99);
         sel  = $urandom_range(9);
         w.data_value = ($urandom_range(15) == 0) ? 32'h0 :
                        ($urandom_range(15) == 0) ? 32'hFFFF_FFFF : $urandom;
         if (roll < 4) begin
            w.cmd      = 2'($urandom_range(3));
            w.position = 8'($urandom_range(255));
         end else if (roll < 5) begin
            w.cmd      = bpl_pkg::CMD_CLEAR;
            w.position = 8'($urandom_range(255));
         end else if (roll < 5 + push_pct) begin
            w.cmd = bpl_pkg::CMD_PUSH;
            if (sel == 0) w.position = 8'd0;
            else if (sel == 1) w.position = cnt[7:0];
            else if (sel == 2) w.position = $urandom_range(1) ? 8'hFF : 8'(cnt + 1);
            else w.position = 8'($urandom_range(0, cnt));
         end else begin
            w.cmd = (roll < 5 + push_pct + pop_pct) ? bpl_pkg::CMD_POP : bpl_pkg::CMD_READ;
            if (sel <= 1) w.position = 8'hFF;
            else if (sel == 2) w.position = cnt[7:0];
            else w.position = (cnt > 0) ? 8'($urandom_range(0, cnt - 1)) : 8'h00;
         end
         send_word(w);
      end
   endtask

   initial begin
      sb = new();
      sb.reset_state();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(make_word(bpl_pkg::CMD_READ, 0, 32'h1));
      send_word(make_word(bpl_pkg::CMD_POP, -1, 32'h2));
      send_word(make_word(bpl_pkg::CMD_POP, 64, 32'h3));
      send_word(make_word(bpl_pkg::CMD_PUSH, 64, 32'hFFFF_FFFF));
      send_word(make_word(bpl_pkg::CMD_PUSH, -1, 32'h4));
      send_word(make_word(bpl_pkg::CMD_PUSH, -128, 32'h5));
      send_word(make_word(bpl_pkg::CMD_PUSH, 2, 32'h6));
      send_word(make_word(bpl_pkg::CMD_PUSH, 1, 32'h0));
      send_word(make_word(bpl_pkg::CMD_PUSH, 0, 32'hA5A5_A5A5));
      send_word(make_word(bpl_pkg::CMD_PUSH, 1, 32'h5A5A_5A5A));
      send_word(make_word(bpl_pkg::CMD_READ, 0, 32'h7));
      send_word(make_word(bpl_pkg::CMD_READ, 3, 32'h8));
      send_word(make_word(bpl_pkg::CMD_READ, 4, 32'h9));
      send_word(make_word(bpl_pkg::CMD_READ, -1, 32'hA));
      send_word(make_word(bpl_pkg::CMD_READ, 127, 32'hB));
      send_word(make_word(bpl_pkg::CMD_POP, -1, 32'hC));
      send_word(make_word(bpl_pkg::CMD_POP, 3, 32'hD));
      send_word(make_word(bpl_pkg::CMD_POP, 0, 32'hE));
      send_word(make_word(bpl_pkg::CMD_CLEAR, 5, 32'hF));
      send_word(make_word(bpl_pkg::CMD_READ, 0, 32'h10));
      change_limit(7'd1);
      send_word(make_word(bpl_pkg::CMD_PUSH, 0, 32'h1234_5678));
      send_word(make_word(bpl_pkg::CMD_PUSH, -1, 32'h11));
      change_limit(7'd0);
      send_word(make_word(bpl_pkg::CMD_POP, -1, 32'h12));
      send_word(make_word(bpl_pkg::CMD_PUSH, 0, 32'h13));

      change_limit(7'd64);
      run_phase(90, 70, 10);
      change_limit(7'd3);
      run_phase(60, 20, 50);
      change_limit(7'd127);
      run_phase(130, 85, 5);
      change_limit(7'd2);
      run_phase(50, 40, 30);
      change_limit(7'd0);
      run_phase(40, 30, 30);
      change_limit(7'd16);
      run_phase(80, 50, 25);
      change_limit(7'($urandom_range(1, 64)));
      run_phase(80, 50, 25);
      change_limit(7'd64);
      run_phase(70, 45, 30);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d requests: push %0d, pop %0d, read %0d, clear %0d, %0d limits",
               sb.n_push + sb.n_pop + sb.n_read + sb.n_clear, sb.n_push, sb.n_pop,
               sb.n_read, sb.n_clear, n_settings + 1);
      $display("Full drops %0d, range errors %0d, empty hits %0d, peak count %0d",
               sb.n_full, sb.n_range, sb.n_empty, sb.peak_count);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d responses missing", sb.errors, sb.pending());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
